/* rtl/scfl_pkg.sv */
// shared types and constants for the size-class free-list allocator
package scfl_pkg;
	localparam int unsigned KIND_W = 1;
	localparam int unsigned SIZE_W = 10;
	localparam int unsigned ADDR_W = 16;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned CFG_W = 17;
	localparam int unsigned CLS_W = 5;
	localparam int unsigned TAG_W = 6;
	localparam int unsigned MAX_REQ = 255;
	localparam int unsigned GRAN_SHIFT = 3;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_SIZE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EXHAUST = 2'd2;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] alloc_addr;
		logic [STAT_W-1:0] status;
	} rsp_t;
endpackage

/* rtl/scfl_req_if.sv */
// valid/ready channel for request beats
interface scfl_req_if;
	logic valid;
	logic ready;
	logic [scfl_pkg::KIND_W-1:0] kind;
	logic [scfl_pkg::SIZE_W-1:0] req_size;
	logic [scfl_pkg::ADDR_W-1:0] free_addr;
	modport source (output valid, kind, req_size, free_addr, input ready);
	modport sink (input valid, kind, req_size, free_addr, output ready);
endinterface

/* rtl/scfl_rsp_if.sv */
// valid/ready channel for result beats
interface scfl_rsp_if;
	logic valid;
	logic ready;
	logic [scfl_pkg::ADDR_W-1:0] alloc_addr;
	logic [scfl_pkg::STAT_W-1:0] status;
	modport source (output valid, alloc_addr, status, input ready);
	modport sink (input valid, alloc_addr, status, output ready);
endinterface

/* rtl/scfl_cfg_if.sv */
// valid/ready write channel for the arena size register
interface scfl_cfg_if;
	logic valid;
	logic ready;
	logic [scfl_pkg::CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* rtl/scfl_ram.sv */
// generic single-port-write ram with registered read
module scfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/size_class_free_list_allocator_unit.sv */
// Size-class free-list allocator. One request beat gives one result beat.
// Free runs through S_FREE and S_FREEW, pop through S_POP and S_POPW, and the
// result is registered in S_OUT; no new request is accepted until it is taken.
// An allocation on an empty class first counts how many of up to REFILL_BLOCKS
// blocks fit, one subtract step per cycle, then writes one link per cycle
// through the single write port of the link memory. The links and tags live in
// memories of ARENA_GRANULES entries, heads in flops with valid bits. No
// clearing pass: untouched links are never read.
module size_class_free_list_allocator_unit #(
	parameter int unsigned ARENA_GRANULES = 8192,
	parameter int unsigned REFILL_BLOCKS = 40
) (
	input logic clk,
	input logic arst_n,
	scfl_req_if.sink req,
	scfl_rsp_if.source rsp,
	scfl_cfg_if.sink cfg
);
	import scfl_pkg::*;

	localparam int unsigned GW = $clog2(ARENA_GRANULES);
	localparam int unsigned HW = 14;
	localparam int unsigned CNT_W = $clog2(REFILL_BLOCKS + 1);
	localparam int unsigned CLASSES = 32;
	localparam logic [CFG_W-1:0] CAP = CFG_W'(ARENA_GRANULES * 8);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_CARVE, S_POP, S_POPW, S_FREE, S_FREEW, S_OUT
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] arena_q, carve_q;
	logic [HW-1:0] heads_q [CLASSES];
	logic [CLASSES-1:0] hv_q;
	logic [CLS_W-1:0] cls_q;
	logic [GW-1:0] g_q;
	logic [CFG_W-1:0] left_q, size_q;
	logic [CNT_W-1:0] n_q, i_q;
	logic [CFG_W-1:0] base_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [STAT_W-1:0] out_stat_q;
	logic out_v_q;

	// link and tag memories
	logic link_we, tag_we;
	logic [GW-1:0] link_wa, link_ra, tag_wa, tag_ra;
	logic [HW-1:0] link_wd, link_rd;
	logic [TAG_W-1:0] tag_wd, tag_rd;

	scfl_ram #(.WIDTH(HW), .DEPTH(ARENA_GRANULES)) u_links (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(link_ra), .rdata(link_rd)
	);
	scfl_ram #(.WIDTH(TAG_W), .DEPTH(ARENA_GRANULES)) u_tags (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(tag_ra), .rdata(tag_rd)
	);

	// arena end in bytes, rounded and capped
	logic [CFG_W-1:0] arena_end;
	always_comb begin
		arena_end = {arena_q[CFG_W-1:3], 3'b000};
		if (arena_end > CAP) begin
			arena_end = CAP;
		end
	end

	// request decode
	logic [SIZE_W-1:0] sz_add;
	logic [CLS_W-1:0] req_cls;
	logic [ADDR_W-1:0] fa_m1;
	assign sz_add = req.req_size + SIZE_W'(8);
	assign req_cls = sz_add[GRAN_SHIFT+CLS_W-1:GRAN_SHIFT] - CLS_W'(1);
	assign fa_m1 = req.free_addr - ADDR_W'(1);
	logic free_ok;
	assign free_ok = (req.free_addr != '0) && (fa_m1[2:0] == 3'b000)
		&& ({3'b000, fa_m1[ADDR_W-1:3]} < ADDR_W'(ARENA_GRANULES));

	// carve address for the current link
	logic [CFG_W-1:0] carve_g;
	assign carve_g = base_q + (CFG_W'(i_q) * {3'b000, size_q[CFG_W-1:3]});
	logic [CFG_W-1:0] gsz;
	assign gsz = {3'b000, size_q[CFG_W-1:3]};

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.alloc_addr = out_addr_q;
	assign rsp.status = out_stat_q;

	// memory access control
	always_comb begin
		link_we = 1'b0;
		link_wa = carve_g[GW-1:0];
		link_wd = '0;
		link_ra = heads_q[cls_q][GW-1:0];
		tag_we = 1'b0;
		tag_wa = g_q;
		tag_wd = TAG_W'(cls_q) + TAG_W'(1);
		tag_ra = g_q;
		case (state_q)
			S_CARVE: begin
				link_we = (i_q < n_q) && (carve_g < CFG_W'(ARENA_GRANULES));
				link_wd = (CNT_W'(i_q + 1'b1) < n_q)
					? {1'b1, 13'((carve_g + gsz))} : '0;
			end
			S_POPW: begin
				tag_we = 1'b1;
			end
			S_FREEW: begin
				link_wa = g_q;
				if (i_q == '0) begin
					// leftover piece links to its own class head
					link_we = 1'b1;
					link_wd = hv_q[cls_q] ? heads_q[cls_q] : '0;
				end else begin
					link_we = (tag_rd != '0) && (tag_rd <= TAG_W'(CLASSES));
					link_wd = heads_q[tag_rd[CLS_W-1:0] - CLS_W'(1)];
					if (!hv_q[tag_rd[CLS_W-1:0] - CLS_W'(1)]) begin
						link_wd = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			arena_q <= 17'h10000;
			carve_q <= '0;
			hv_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				arena_q <= cfg.data;
			end
			if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cls_q <= req_cls;
						g_q <= fa_m1[GW+2:3];
						out_addr_q <= '0;
						if (req.kind == KIND_FREE) begin
							if (free_ok) begin
								state_q <= S_FREE;
							end else begin
								out_stat_q <= ST_IGNORED;
								state_q <= S_OUT;
							end
						end else if (req.req_size > SIZE_W'(MAX_REQ)) begin
							out_stat_q <= ST_SIZE;
							state_q <= S_OUT;
						end else if (hv_q[req_cls]) begin
							state_q <= S_POP;
						end else begin
							size_q <= CFG_W'({sz_add[SIZE_W-1:3], 3'b000});
							left_q <= (arena_end > carve_q) ? arena_end - carve_q : '0;
							n_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				// count blocks that fit by repeated subtraction; if none fit, push any leftover piece and report exhaustion
				S_DIV: begin
					if (n_q != CNT_W'(REFILL_BLOCKS) && left_q >= size_q) begin
						left_q <= left_q - size_q;
						n_q <= n_q + 1'b1;
					end else if (n_q == '0) begin
						if (left_q != '0) begin
							heads_q[left_q[CLS_W+2:3] - CLS_W'(1)] <=
								hv_q[left_q[CLS_W+2:3] - CLS_W'(1)]
								? heads_q[left_q[CLS_W+2:3] - CLS_W'(1)] : '0;
							g_q <= carve_q[GW+2:3];
							i_q <= '0;
							cls_q <= left_q[CLS_W+2:3] - CLS_W'(1);
							state_q <= S_FREEW;
						end else begin
							state_q <= S_OUT;
						end
						out_stat_q <= ST_EXHAUST;
						carve_q <= arena_end;
					end else begin
						base_q <= {3'b000, carve_q[CFG_W-1:3]};
						i_q <= '0;
						state_q <= S_CARVE;
					end
				end
				S_CARVE: begin
					if (i_q == n_q) begin
						heads_q[cls_q] <= {1'b1, 13'(base_q)};
						hv_q[cls_q] <= 1'b1;
						carve_q <= carve_q + CFG_W'(n_q) * size_q;
						state_q <= S_POP;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_POP: begin
					g_q <= heads_q[cls_q][GW-1:0];
					if ({1'b0, heads_q[cls_q][12:0]} >= HW'(ARENA_GRANULES)) begin
						out_stat_q <= ST_EXHAUST;
						state_q <= S_OUT;
					end else begin
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					heads_q[cls_q] <= link_rd;
					hv_q[cls_q] <= link_rd[HW-1];
					out_addr_q <= ADDR_W'({g_q, 3'b001});
					out_stat_q <= ST_OK;
					state_q <= S_OUT;
				end
				S_FREE: begin
					i_q <= '1;
					state_q <= S_FREEW;
				end
				S_FREEW: begin
					if (i_q == '0) begin
						// leftover piece push after exhaustion
						heads_q[cls_q] <= {1'b1, 13'(g_q)};
						hv_q[cls_q] <= 1'b1;
						state_q <= S_OUT;
					end else begin
						if (link_we) begin
							heads_q[tag_rd[CLS_W-1:0] - CLS_W'(1)] <= {1'b1, 13'(g_q)};
							hv_q[tag_rd[CLS_W-1:0] - CLS_W'(1)] <= 1'b1;
							out_stat_q <= ST_OK;
						end else begin
							out_stat_q <= ST_IGNORED;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* rtl/scfl_checker.sv */
// port-level checks for the allocator, bound to the top level
module scfl_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [15:0] alloc_addr,
	input logic [1:0] status
);
	import scfl_pkg::*;

	// a held result stays valid with a stable address
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(alloc_addr))
		else $error("result changed while stalled");

	// only successful requests carry an address
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> alloc_addr == '0)
		else $error("address on failed request");

	// granted addresses are granule base plus one
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && alloc_addr != '0 |-> alloc_addr[2:0] == 3'b001)
		else $error("misaligned address");

	// no new request while a result is pending
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken with result pending");
endmodule

bind size_class_free_list_allocator_unit scfl_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.alloc_addr(rsp.alloc_addr), .status(rsp.status)
);

/* verif/size_class_free_list_allocator_unit_test.sv */
`timescale 1ns / 100ps
// testbench for the size-class free-list allocator: random and directed traffic, self-checking
module size_class_free_list_allocator_unit_test;
	import scfl_pkg::*;

	localparam int GRANULES = 8192;
	localparam int CLASSES = 32;
	localparam int REFILL = 40;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] req_size;
		logic [ADDR_W-1:0] free_addr;
	} beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0] alloc_addr;
		logic [STAT_W-1:0] status;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scfl_req_if req();
	scfl_rsp_if rsp();
	scfl_cfg_if cfg();

	size_class_free_list_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	always #1 clk = ~clk;

	// allocator shadow state
	logic [16:0] arena_reg;
	logic [13:0] heads [CLASSES];
	logic [13:0] links [GRANULES];
	logic [5:0] tags [GRANULES];
	logic [16:0] carve;

	beat_t pending [$];
	grant_t grants_due [$];
	logic [ADDR_W-1:0] live_blocks [$];

	int errors = 0;
	int beats_sent = 0;
	int beats_seen = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic int arena_end();
		int a;
		a = int'(arena_reg) & ~7;
		return (a > GRANULES * 8) ? GRANULES * 8 : a;
	endfunction

	function automatic void link_block(input int c, input int g);
		if (c >= CLASSES || g >= GRANULES) return;
		links[g] = heads[c];
		heads[c] = {1'b1, 13'(g)};
	endfunction

	// carve fresh blocks for one class, or push any leftover piece when none fit
	function automatic void carve_class(input int c, input int sz);
		int fin, left, n, base, g;
		fin = arena_end();
		left = (fin > int'(carve)) ? fin - int'(carve) : 0;
		n = REFILL;
		if (left < n * sz) begin
			if (left >= sz) begin
				n = left / sz;
			end else begin
				if (left > 0) link_block(left / 8 - 1, int'(carve) / 8);
				carve = 17'(fin);
				return;
			end
		end
		base = int'(carve) / 8;
		for (int i = 0; i < n; i++) begin
			g = base + i * (sz / 8);
			if (g >= GRANULES) break;
			links[g] = (i + 1 < n) ? {1'b1, 13'(g + sz / 8)} : 14'd0;
		end
		heads[c] = {1'b1, 13'(base)};
		carve = carve + 17'(n * sz);
	endfunction

	// expected grant for one request
	function automatic grant_t allocate_or_free(input beat_t b);
		grant_t r;
		int sz, c, g, t;
		r = '0;
		r.status = ST_OK;
		if (b.kind == KIND_ALLOC) begin
			if (b.req_size > MAX_REQ) begin
				r.status = ST_SIZE;
			end else begin
				sz = (int'(b.req_size) + 8) & ~7;
				c = sz / 8 - 1;
				if (!heads[c][13]) carve_class(c, sz);
				if (!heads[c][13]) begin
					r.status = ST_EXHAUST;
				end else begin
					g = heads[c][12:0];
					heads[c] = links[g];
					tags[g] = 6'(c + 1);
					r.alloc_addr = 16'(g * 8 + 1);
				end
			end
		end else begin
			if (b.free_addr == 0 || b.free_addr[2:0] != 3'd1) begin
				r.status = ST_IGNORED;
			end else begin
				g = (int'(b.free_addr) - 1) / 8;
				t = tags[g];
				if (t == 0 || t > CLASSES) r.status = ST_IGNORED;
				else link_block(t - 1, g);
			end
		end
		return r;
	endfunction

	// driver: one beat from the queue, with random gaps
	always @(posedge clk) begin
		if (req.valid && req.ready) beats_sent <= beats_sent + 1;
		if (!req.valid || req.ready) begin
			if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				beat_t b;
				b = pending.pop_front();
				grants_due.push_back(allocate_or_free(b));
				req.valid <= 1'b1;
				req.kind <= b.kind;
				req.req_size <= b.req_size;
				req.free_addr <= b.free_addr;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (rsp.valid && rsp.ready) begin
			beats_seen <= beats_seen + 1;
			if (grants_due.size() == 0) begin
				report($sformatf("unexpected beat addr=%0h st=%0d", rsp.alloc_addr, rsp.status));
			end else begin
				grant_t e;
				e = grants_due.pop_front();
				if (rsp.alloc_addr !== e.alloc_addr)
					report($sformatf("alloc_addr %0h, want %0h", rsp.alloc_addr, e.alloc_addr));
				if (rsp.status !== e.status)
					report($sformatf("status %0d, want %0d", rsp.status, e.status));
				if (e.status == ST_OK && e.alloc_addr != 0) live_blocks.push_back(e.alloc_addr);
			end
		end
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic queue_beat(input logic [KIND_W-1:0] k, input int sz, input int a);
		beat_t b;
		b.kind = k;
		b.req_size = SIZE_W'(sz);
		b.free_addr = ADDR_W'(a);
		pending.push_back(b);
	endtask

	task automatic drain();
		while (pending.size() > 0 || grants_due.size() > 0 || req.valid) @(posedge clk);
		repeat (REFILL + 20) @(posedge clk);
	endtask

	task automatic write_arena(input int v);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= 17'(v);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		arena_reg = 17'(v);
	endtask

	// mostly allocs of small sizes, frees of live blocks, some noise
	task automatic random_phase(input int n);
		int r, idx;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50) begin
				queue_beat(KIND_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(1023)
					: $urandom_range(255), 0);
			end else if (r < 88 && live_blocks.size() > 0) begin
				idx = $urandom_range(live_blocks.size() - 1);
				queue_beat(KIND_FREE, $urandom_range(1023), live_blocks[idx]);
				live_blocks.delete(idx);
			end else begin
				// null or misaligned frees only, never a stray granule
				r = $urandom_range(65535);
				if (r[2:0] == 3'd1) r = r ^ 1;
				queue_beat(KIND_FREE, $urandom_range(1023), ($urandom_range(3) == 0) ? 0 : r);
			end
			if (i % 50 == 49) drain();
		end
		drain();
	endtask

	initial begin
		req.valid = 1'b0;
		req.kind = '0;
		req.req_size = '0;
		req.free_addr = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arena_reg = 17'd65536;
		carve = '0;
		for (int i = 0; i < CLASSES; i++) heads[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: size extremes, bad sizes, bad frees, small arena exhaustion
		write_arena(8);
		queue_beat(KIND_ALLOC, 0, 0);
		queue_beat(KIND_ALLOC, 0, 0);
		queue_beat(KIND_ALLOC, 255, 0);
		queue_beat(KIND_FREE, 0, 0);
		queue_beat(KIND_FREE, 0, 2);
		queue_beat(KIND_FREE, 1023, 16'hfffe);
		drain();
		queue_beat(KIND_FREE, 0, 1);
		queue_beat(KIND_ALLOC, 0, 0);
		queue_beat(KIND_ALLOC, 256, 0);
		queue_beat(KIND_ALLOC, 1023, 0);
		drain();
		write_arena(100);
		queue_beat(KIND_ALLOC, 40, 0);
		queue_beat(KIND_ALLOC, 40, 0);
		queue_beat(KIND_ALLOC, 7, 0);
		queue_beat(KIND_ALLOC, 8, 0);
		queue_beat(KIND_ALLOC, 100, 0);
		drain();
		write_arena(131071);
		queue_beat(KIND_ALLOC, 255, 0);
		queue_beat(KIND_ALLOC, 128, 0);
		queue_beat(KIND_FREE, 0, 1);
		queue_beat(KIND_FREE, 0, 1);
		queue_beat(KIND_ALLOC, 0, 0);
		queue_beat(KIND_ALLOC, 0, 0);
		drain();
		live_blocks.delete();

		// random phases under different gap patterns and arena sizes
		write_arena(65536);
		random_phase(500);
		send_idle_pct = 75;
		write_arena(24000);
		random_phase(500);
		send_idle_pct = 0;
		stall_pct = 75;
		write_arena(4096);
		random_phase(500);
		send_idle_pct = 23;
		stall_pct = 23;
		write_arena(65528);
		random_phase(500);
		stall_pct = 0;

		$display("covered %0d request beats and %0d result beats over seven arena settings",
			beats_sent, beats_seen);
		$display("gap patterns: none, sender idle, receiver stall, both");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end
endmodule

/* size_class_free_list_allocator_unit.f */
rtl/scfl_pkg.sv
rtl/scfl_req_if.sv
rtl/scfl_rsp_if.sv
rtl/scfl_cfg_if.sv
rtl/scfl_ram.sv
rtl/size_class_free_list_allocator_unit.sv
rtl/scfl_checker.sv
verif/size_class_free_list_allocator_unit_test.sv
